// ----- hdl/krs_pkg.sv -----
// Shared types and constants for the keyed range statistics block.
// Used by the controller, datapath, top level and testbench; depends on nothing.
package krs_pkg;

   localparam int KEY_W   = 20;
   localparam int DIST_W  = 20;
   localparam int SUM_W   = 36;
   localparam int CNT_W   = 16;
   localparam int STAT_W  = 3;
   localparam int TOPC_W  = 6;

   localparam logic [STAT_W-1:0] ST_UPDATED = 3'd0;
   localparam logic [STAT_W-1:0] ST_NEW     = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STAT_W-1:0] ST_REPORT  = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   localparam logic CSR_TOP_COUNT   = 1'b0;
   localparam logic CSR_MIN_SAMPLES = 1'b1;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;
   localparam logic [SUM_W-1:0] SUM_MAX   = '1;

   // One table entry as it is stored in the table RAM.
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [DIST_W-1:0] min_d;
      logic [DIST_W-1:0] max_d;
      logic [SUM_W-1:0]  sum;
      logic [CNT_W-1:0]  cnt;
   } krs_entry_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic scan_clear;   // restart a table scan
      logic scan_step;    // read the entry at the scan index
      logic rep_mode;     // scan looks for report candidates, not for the key
      logic add_write;    // write the updated or new entry
      logic pick_best;    // record the best entry of a report pass as picked
      logic clear_picks;  // forget all picks of the previous report
      logic load_result;  // capture the result register
   } krs_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic scan_done;
      logic hit;
      logic found;
   } krs_stat_type;

endpackage

// ----- hdl/krs_ctrl.sv -----
// Controller state machine for the keyed range statistics block.
// Depends on krs_pkg; drives the datapath by command struct.
module krs_ctrl #(
   parameter int TOP_MAX = 50
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic                  rsp_last,
   input  logic [krs_pkg::TOPC_W-1:0] top_count,
   input  krs_pkg::krs_stat_type stat,
   output krs_pkg::krs_cmd_type  cmd
);
   import krs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_ADD_SCAN, S_ADD_DONE, S_REP_SCAN, S_REP_EMIT
   } state_type;

   localparam int NW = $clog2(TOP_MAX + 1);

   state_type     state_ff;
   logic          valid_ff;
   logic          last_ff;
   logic          pending_ff;
   logic [NW-1:0] emitted_ff;
   logic [NW-1:0] limit;
   logic          accept;
   logic          send;
   logic          send_last;

   always_comb begin
      if (top_count == '0) limit = NW'(1);
      else if (32'(top_count) > TOP_MAX) limit = NW'(TOP_MAX);
      else limit = NW'(top_count);
   end

   assign req_stall     = (state_ff != S_IDLE) || valid_ff;
   assign accept        = req_valid && !req_stall;
   assign rsp_valid     = valid_ff;
   assign rsp_last      = last_ff;

   // A report pick waits in the result register until the next pass shows
   // whether another entry follows, so that the last one can be marked.
   always_comb begin
      cmd       = '0;
      send      = 1'b0;
      send_last = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.scan_clear  = 1'b1;
               cmd.clear_picks = (req_cmd == CMD_REPORT);
            end
         end
         S_ADD_SCAN: cmd.scan_step = !stat.hit && !stat.scan_done;
         S_ADD_DONE: begin
            cmd.add_write   = 1'b1;
            cmd.load_result = 1'b1;
            send            = 1'b1;
            send_last       = 1'b1;
         end
         S_REP_SCAN: begin
            cmd.rep_mode  = 1'b1;
            cmd.scan_step = !stat.scan_done;
         end
         S_REP_EMIT: begin
            cmd.rep_mode = 1'b1;
            if (!valid_ff) begin
               if (stat.found) begin
                  if (pending_ff) begin
                     send = 1'b1;
                  end else begin
                     cmd.load_result = 1'b1;
                     cmd.pick_best   = 1'b1;
                     if (emitted_ff + 1'b1 == limit) begin
                        send      = 1'b1;
                        send_last = 1'b1;
                     end else begin
                        cmd.scan_clear = 1'b1;
                     end
                  end
               end else begin
                  cmd.load_result = !pending_ff;
                  send            = 1'b1;
                  send_last       = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= 1'b0;
         last_ff    <= 1'b0;
         pending_ff <= 1'b0;
         emitted_ff <= '0;
      end else begin
         if (send) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
         if (send) last_ff <= send_last;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  emitted_ff <= '0;
                  pending_ff <= 1'b0;
                  state_ff   <= (req_cmd == CMD_REPORT) ? S_REP_SCAN : S_ADD_SCAN;
               end
            end
            S_ADD_SCAN: if (stat.hit || stat.scan_done) state_ff <= S_ADD_DONE;
            S_ADD_DONE: state_ff <= S_IDLE;
            S_REP_SCAN: if (stat.scan_done) state_ff <= S_REP_EMIT;
            S_REP_EMIT: begin
               if (!valid_ff) begin
                  if (stat.found) begin
                     if (pending_ff) begin
                        pending_ff <= 1'b0;
                     end else begin
                        emitted_ff <= emitted_ff + 1'b1;
                        if (emitted_ff + 1'b1 == limit) begin
                           state_ff <= S_IDLE;
                        end else begin
                           pending_ff <= 1'b1;
                           state_ff   <= S_REP_SCAN;
                        end
                     end
                  end else begin
                     pending_ff <= 1'b0;
                     state_ff   <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accepted while busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(emitted_ff) <= TOP_MAX) else $error("report overran TOP_MAX");
   a_add_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD_DONE) |=> (valid_ff && last_ff))
      else $error("add gave no single result");
`endif
endmodule

// ----- hdl/krs_dp.sv -----
// Datapath for the keyed range statistics block: table RAM, scan and best tracker.
// Depends on krs_pkg; commanded by krs_ctrl. Also holds the generic table RAM.
module krs_ram #(
   parameter int WIDTH = 112,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end
endmodule

module krs_dp #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_accept,
   input  logic [krs_pkg::KEY_W-1:0]     req_route_id,
   input  logic [krs_pkg::DIST_W-1:0]    req_distance,
   input  logic [krs_pkg::CNT_W-1:0]     min_samples,
   input  krs_pkg::krs_cmd_type          cmd,
   output krs_pkg::krs_stat_type         stat,
   output logic [krs_pkg::STAT_W-1:0]    rsp_status,
   output logic [krs_pkg::KEY_W-1:0]     rsp_out_route_id,
   output logic [krs_pkg::DIST_W-1:0]    rsp_out_min,
   output logic [krs_pkg::DIST_W-1:0]    rsp_out_max,
   output logic [krs_pkg::SUM_W-1:0]     rsp_out_sum,
   output logic [krs_pkg::CNT_W-1:0]     rsp_out_count
);
   import krs_pkg::*;

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int UW = $clog2(TABLE_ENTRIES + 1);

   logic [UW-1:0]     used_ff, idx_ff;
   logic [IW-1:0]     rd_idx_ff, best_ff, last_idx_ff;
   logic              rd_ok_ff, hit_ff, found_ff, have_last_ff;
   logic [KEY_W-1:0]  rkey_ff;
   logic [DIST_W-1:0] rdist_ff, bsp_ff, last_sp_ff;
   krs_entry_type     ent_ff, rsp_ent_ff;
   logic [STAT_W-1:0] rsp_status_ff;

   krs_entry_type     rd_ent, upd_ent, new_ent, wr_ent, res_ent;
   logic [STAT_W-1:0] res_status;
   logic [IW-1:0]     wr_addr;
   logic              wr_en, rd_go, full, after_last, qual, take_hit, take_best;
   logic [DIST_W-1:0] sp;
   logic [SUM_W:0]    sum_wide;

   // Entries below the fill count are valid; they were allocated in order.
   assign full  = (used_ff == UW'(TABLE_ENTRIES));
   assign rd_go = cmd.scan_step && (idx_ff < used_ff);

   // Picks follow spread descending, then index ascending, so the entries left
   // for a pass are exactly those that come after the previous pick.
   assign sp         = rd_ent.max_d - rd_ent.min_d;
   assign after_last = !have_last_ff || (sp < last_sp_ff) ||
                       ((sp == last_sp_ff) && (rd_idx_ff > last_idx_ff));
   assign qual       = (rd_ent.cnt >= min_samples) && after_last;
   assign take_hit   = !cmd.scan_clear && rd_ok_ff && !cmd.rep_mode && !hit_ff &&
                       (rd_ent.key == rkey_ff);
   assign take_best  = !cmd.scan_clear && rd_ok_ff && cmd.rep_mode && qual &&
                       (!found_ff || sp > bsp_ff);

   assign stat.scan_done = (idx_ff >= used_ff) && !rd_ok_ff;
   assign stat.hit       = hit_ff;
   assign stat.found     = found_ff;

   assign sum_wide = {1'b0, ent_ff.sum} + (SUM_W+1)'(rdist_ff);

   always_comb begin
      upd_ent.key   = ent_ff.key;
      upd_ent.min_d = (rdist_ff < ent_ff.min_d) ? rdist_ff : ent_ff.min_d;
      upd_ent.max_d = (rdist_ff > ent_ff.max_d) ? rdist_ff : ent_ff.max_d;
      upd_ent.sum   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      upd_ent.cnt   = (ent_ff.cnt == COUNT_MAX) ? COUNT_MAX : ent_ff.cnt + 1'b1;
      new_ent.key   = rkey_ff;
      new_ent.min_d = rdist_ff;
      new_ent.max_d = rdist_ff;
      new_ent.sum   = SUM_W'(rdist_ff);
      new_ent.cnt   = CNT_W'(1);
   end

   assign wr_ent  = hit_ff ? upd_ent : new_ent;
   assign wr_addr = hit_ff ? best_ff : used_ff[IW-1:0];
   assign wr_en   = cmd.add_write && (hit_ff || !full);

   always_comb begin
      res_status = ST_EMPTY;
      res_ent    = '0;
      if (cmd.add_write) begin
         if (hit_ff) begin
            res_status = ST_UPDATED;
            res_ent    = upd_ent;
         end else if (full) begin
            res_status  = ST_FULL;
            res_ent.key = rkey_ff;
         end else begin
            res_status = ST_NEW;
            res_ent    = new_ent;
         end
      end else if (found_ff) begin
         res_status = ST_REPORT;
         res_ent    = ent_ff;
      end
   end

   krs_ram #(.WIDTH($bits(krs_entry_type)), .DEPTH(TABLE_ENTRIES)) u_table (
      .clock, .wr_en, .wr_addr, .wr_data(wr_ent), .rd_addr(idx_ff[IW-1:0]),
      .rd_data(rd_ent)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         idx_ff       <= '0;
         rd_ok_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         found_ff     <= 1'b0;
         have_last_ff <= 1'b0;
      end else begin
         if (cmd.add_write && !hit_ff && !full) used_ff <= used_ff + 1'b1;
         if (cmd.scan_clear) begin
            idx_ff   <= '0;
            rd_ok_ff <= 1'b0;
            hit_ff   <= 1'b0;
            found_ff <= 1'b0;
         end else begin
            rd_ok_ff <= rd_go;
            if (rd_go) idx_ff <= idx_ff + 1'b1;
            if (take_hit) hit_ff <= 1'b1;
            if (take_best) found_ff <= 1'b1;
         end
         if (cmd.clear_picks) have_last_ff <= 1'b0;
         else if (cmd.pick_best) have_last_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rkey_ff  <= req_route_id;
         rdist_ff <= req_distance;
      end
      rd_idx_ff <= idx_ff[IW-1:0];
      if (take_hit || take_best) begin
         best_ff <= rd_idx_ff;
         ent_ff  <= rd_ent;
      end
      if (take_best) bsp_ff <= sp;
      if (cmd.pick_best) begin
         last_sp_ff  <= bsp_ff;
         last_idx_ff <= best_ff;
      end
      if (cmd.load_result) begin
         rsp_status_ff <= res_status;
         rsp_ent_ff    <= res_ent;
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_out_route_id = rsp_ent_ff.key;
   assign rsp_out_min      = rsp_ent_ff.min_d;
   assign rsp_out_max      = rsp_ent_ff.max_d;
   assign rsp_out_sum      = rsp_ent_ff.sum;
   assign rsp_out_count    = rsp_ent_ff.cnt;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(TABLE_ENTRIES)) else $error("fill count overflow");
   a_alloc: assert property (@(posedge clock) disable iff (reset)
      (cmd.add_write && !hit_ff && !full) |=> used_ff == $past(used_ff) + 1'b1)
      else $error("allocation lost");
   a_pick_found: assert property (@(posedge clock) disable iff (reset)
      cmd.pick_best |-> found_ff) else $error("picked without a candidate");
   a_read_valid: assert property (@(posedge clock) disable iff (reset)
      rd_ok_ff |-> ({1'b0, rd_idx_ff} < used_ff)) else $error("read past fill count");
`endif
endmodule

// ----- hdl/keyed_range_stats_top_k.sv -----
// Top level of the keyed range statistics block with top-k spread report.
// Depends on krs_pkg, krs_ctrl and krs_dp (with its table RAM).
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | cmd, route_id, distance
//   rsp     | out       | rsp_valid / rsp_stall | status, ids, min, max, sum, count, last
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// An add searches the key by reading one entry per cycle from the table RAM, whose
// read data is registered, and stops at a hit; unless the table is full and the key
// is new, one write then updates or allocates the entry as the result is captured.
// A report makes one pass over the used entries per result, plus a closing pass
// when fewer than top_count entries qualify (zero counts as one, capped at TOP_MAX).
// Reset is synchronous and clears the fill count and control registers; table
// entries are only read below the fill count. A stalled result holds the block.
module keyed_range_stats_top_k #(
   parameter int TABLE_ENTRIES = 256,
   parameter int TOP_MAX       = 50
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [krs_pkg::KEY_W-1:0]           req_route_id,
   input  logic [krs_pkg::DIST_W-1:0]          req_distance,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [krs_pkg::STAT_W-1:0]          rsp_status,
   output logic [krs_pkg::KEY_W-1:0]           rsp_out_route_id,
   output logic [krs_pkg::DIST_W-1:0]          rsp_out_min,
   output logic [krs_pkg::DIST_W-1:0]          rsp_out_max,
   output logic [krs_pkg::SUM_W-1:0]           rsp_out_sum,
   output logic [krs_pkg::CNT_W-1:0]           rsp_out_count,
   output logic                                rsp_last_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [krs_pkg::CNT_W-1:0]           csr_wdata
);
   import krs_pkg::*;

   logic [TOPC_W-1:0] top_count_ff;
   logic [CNT_W-1:0]  min_samples_ff;
   krs_cmd_type       cmd;
   krs_stat_type      stat;

   // Configuration writes are always taken; the block is idle by contract.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff   <= TOPC_W'(50);
         min_samples_ff <= CNT_W'(2);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TOP_COUNT:   top_count_ff   <= csr_wdata[TOPC_W-1:0];
            CSR_MIN_SAMPLES: min_samples_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   krs_ctrl #(.TOP_MAX(TOP_MAX)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_cmd, .rsp_stall,
      .rsp_valid, .rsp_last(rsp_last_item), .top_count(top_count_ff),
      .stat, .cmd
   );

   krs_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock, .reset, .req_accept(req_valid && !req_stall),
      .req_route_id, .req_distance, .min_samples(min_samples_ff),
      .cmd, .stat, .rsp_status, .rsp_out_route_id,
      .rsp_out_min, .rsp_out_max, .rsp_out_sum, .rsp_out_count
   );

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accepted while result pending");
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_status)) else $error("payload moved");
`endif
endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for keyed_range_stats_top_k, with a built-in predictor.
// Depends on krs_pkg and the keyed_range_stats_top_k RTL, and on nothing else.
`timescale 1ns / 100ps

module tb_top;
   import krs_pkg::*;

   localparam int TABLE_SIZE  = 256;
   localparam int TOP_LIMIT   = 50;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [KEY_W-1:0]  route_id;
      logic [DIST_W-1:0] min_dist;
      logic [DIST_W-1:0] max_dist;
      logic [SUM_W-1:0]  sum;
      logic [CNT_W-1:0]  count;
      logic              last;
   } route_result_type;

   // The scoreboard keeps its own copy of the route table and the two registers.
   // Every accepted request is turned into the results the block should return.
   class route_stats_scoreboard;
      logic [TOPC_W-1:0] top_count;
      logic [CNT_W-1:0]  min_samples;
      bit                valid_q [TABLE_SIZE];
      logic [KEY_W-1:0]  key_q   [TABLE_SIZE];
      logic [DIST_W-1:0] min_q   [TABLE_SIZE];
      logic [DIST_W-1:0] max_q   [TABLE_SIZE];
      logic [SUM_W-1:0]  sum_q   [TABLE_SIZE];
      logic [CNT_W-1:0]  count_q [TABLE_SIZE];
      int                used;
      route_result_type  pending_results[$];
      int                mismatches;

      function new();
         top_count   = 6'd50;
         min_samples = 16'd2;
         used        = 0;
         mismatches  = 0;
         foreach (valid_q[i]) valid_q[i] = 0;
      endfunction

      function void note_config(logic idx, logic [CNT_W-1:0] data);
         if (idx == CSR_TOP_COUNT) top_count = data[TOPC_W-1:0];
         else min_samples = data;
      endfunction

      function route_result_type entry_result(int i, logic [STAT_W-1:0] st, logic last);
         route_result_type r;
         r = '{st, key_q[i], min_q[i], max_q[i], sum_q[i], count_q[i], last};
         return r;
      endfunction

      function void add_sample(logic [KEY_W-1:0] key, logic [DIST_W-1:0] sample_dist);
         logic [SUM_W:0] wide_sum;
         for (int i = 0; i < used; i++) begin
            if (valid_q[i] && key_q[i] == key) begin
               if (count_q[i] != COUNT_MAX) count_q[i]++;
               if (sample_dist < min_q[i]) min_q[i] = sample_dist;
               if (sample_dist > max_q[i]) max_q[i] = sample_dist;
               wide_sum = {1'b0, sum_q[i]} + (SUM_W+1)'(sample_dist);
               sum_q[i] = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
               pending_results.push_back(entry_result(i, ST_UPDATED, 1'b1));
               return;
            end
         end
         if (used >= TABLE_SIZE) begin
            pending_results.push_back(route_result_type'{ST_FULL, key, '0, '0, '0, '0, 1'b1});
            return;
         end
         valid_q[used] = 1;
         key_q[used]   = key;
         min_q[used]   = sample_dist;
         max_q[used]   = sample_dist;
         sum_q[used]   = SUM_W'(sample_dist);
         count_q[used] = CNT_W'(1);
         pending_results.push_back(entry_result(used, ST_NEW, 1'b1));
         used++;
      endfunction

      // Repeated selection of the widest remaining spread; a strict compare keeps
      // the earliest inserted entry on ties.
      function void build_report();
         bit                picked[TABLE_SIZE];
         int                limit, n, best;
         bit                found;
         logic [DIST_W-1:0] best_spread, spread;
         limit = (top_count == 0) ? 1 : (top_count > TOP_LIMIT) ? TOP_LIMIT : top_count;
         n = 0;
         while (n < limit) begin
            found = 0;
            best = 0;
            best_spread = '0;
            for (int i = 0; i < used; i++) begin
               if (!valid_q[i] || picked[i] || count_q[i] < min_samples) continue;
               spread = max_q[i] - min_q[i];
               if (!found || spread > best_spread) begin
                  found = 1;
                  best = i;
                  best_spread = spread;
               end
            end
            if (!found) break;
            picked[best] = 1;
            pending_results.push_back(entry_result(best, ST_REPORT, 1'b0));
            n++;
         end
         if (n == 0)
            pending_results.push_back(route_result_type'{ST_EMPTY, '0, '0, '0, '0, '0, 1'b1});
         else pending_results[pending_results.size()-1].last = 1'b1;
      endfunction

      function void note_request(logic cmd, logic [KEY_W-1:0] key,
                                 logic [DIST_W-1:0] sample_dist);
         if (cmd == CMD_ADD) add_sample(key, sample_dist);
         else build_report();
      endfunction

      function void check_response(route_result_type got);
         route_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response %p", got);
            return;
         end
         want = pending_results.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_cmd;
   logic [KEY_W-1:0]    req_route_id;
   logic [DIST_W-1:0]   req_distance;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STAT_W-1:0]   rsp_status;
   logic [KEY_W-1:0]    rsp_out_route_id;
   logic [DIST_W-1:0]   rsp_out_min;
   logic [DIST_W-1:0]   rsp_out_max;
   logic [SUM_W-1:0]    rsp_out_sum;
   logic [CNT_W-1:0]    rsp_out_count;
   logic                rsp_last_item;
   logic                csr_valid;
   logic                csr_ready;
   logic                csr_index;
   logic [CNT_W-1:0]    csr_wdata;

   route_stats_scoreboard sb;
   bit                    idling_on;
   int                    stall_left;
   int                    cycle_count;
   logic [KEY_W-1:0]      key_pool[24];

   keyed_range_stats_top_k u_dut (.*);

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // A runaway run, for instance a lost response, ends here as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // The response side stalls in random bursts while idling is enabled.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
         if (idling_on && $urandom_range(0, 7) == 0)
            stall_left = int'($urandom_range(1, 18)) - 1;
         if (stall_left > 0 || (idling_on && $urandom_range(0, 15) == 0)) rsp_stall = 1'b1;
      end
   end

   // Each response transaction is checked at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response('{rsp_status, rsp_out_route_id, rsp_out_min, rsp_out_max,
                             rsp_out_sum, rsp_out_count, rsp_last_item});
   end

   // Drives one request transaction and hands it to the predictor once accepted.
   // All calls start and end on a falling edge.
   task automatic send_request(logic cmd, logic [KEY_W-1:0] key,
                               logic [DIST_W-1:0] sample_dist);
      if (idling_on && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 18)) @(negedge clock);
      req_valid    = 1'b1;
      req_cmd      = cmd;
      req_route_id = key;
      req_distance = sample_dist;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(cmd, key, sample_dist);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // Registers change only with the block idle, so every write drains first.
   task automatic write_csr(logic idx, logic [CNT_W-1:0] data);
      wait_drained();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.note_config(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic add(logic [KEY_W-1:0] key, logic [DIST_W-1:0] sample_dist);
      send_request(CMD_ADD, key, sample_dist);
   endtask

   task automatic report();
      send_request(CMD_REPORT, KEY_W'($urandom_range(0, 20'hFFFFF)),
                   DIST_W'($urandom_range(0, 20'hFFFFF)));
   endtask

   initial begin
      logic [CNT_W-1:0] data;
      sb           = new();
      idling_on    = 1'b1;
      stall_left   = 0;
      cycle_count  = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_cmd      = CMD_ADD;
      req_route_id = '0;
      req_distance = '0;
      rsp_stall    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = CSR_TOP_COUNT;
      csr_wdata    = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed part: an empty report, new entries and updates at the extremes
      // of the fields, a zero-spread tie, and every register corner.
      report();
      add(20'h00000, 20'h00000);
      add(20'h00000, 20'hFFFFF);
      add(20'hFFFFF, 20'h00005);
      add(20'hFFFFF, 20'h00005);
      add(20'h12345, 20'd100);
      add(20'h12345, 20'd900);
      add(20'h6789A, 20'd900);
      add(20'h00000, 20'd7);
      report();
      write_csr(CSR_MIN_SAMPLES, 16'd0);   // Every valid entry qualifies.
      report();
      write_csr(CSR_TOP_COUNT, 16'd1);
      report();
      write_csr(CSR_TOP_COUNT, 16'd0);     // Zero behaves as one.
      report();
      write_csr(CSR_TOP_COUNT, 16'hFFFF);  // Above the maximum behaves as fifty.
      report();
      write_csr(CSR_MIN_SAMPLES, 16'hFFFF);
      report();

      // Random part: mostly adds over a small key pool so that entries collect
      // samples, with reports in between and new register settings per phase.
      foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom_range(0, 20'hFFFFF));
      key_pool[0] = 20'h00000;
      key_pool[1] = 20'hFFFFF;
      for (int phase = 0; phase < 5; phase++) begin
         data = CNT_W'($urandom_range(0, 16'hFFFF));
         data[TOPC_W-1:0] = (phase == 0) ? 6'd50 : (phase == 1) ? 6'd1 :
                            TOPC_W'($urandom_range(1, 63));
         write_csr(CSR_TOP_COUNT, data);
         write_csr(CSR_MIN_SAMPLES, (phase == 4) ? 16'd0 : CNT_W'($urandom_range(1, 6)));
         for (int n = 0; n < 34; n++) begin
            if ($urandom_range(0, 11) == 0) report();
            else if ($urandom_range(0, 3) == 0)
               add(key_pool[$urandom_range(0, 23)], DIST_W'($urandom_range(0, 20'hFFFFF)));
            else
               add(key_pool[$urandom_range(0, 23)], DIST_W'($urandom_range(0, 4000)));
         end
         report();
      end

      // Final part, without idling: a few more samples and full reports.
      idling_on = 1'b0;
      wait_drained();
      write_csr(CSR_TOP_COUNT, 16'd50);
      write_csr(CSR_MIN_SAMPLES, 16'd1);
      repeat (12)
         add(key_pool[$urandom_range(0, 23)], DIST_W'($urandom_range(0, 20'hFFFFF)));
      report();
      add(key_pool[2], 20'd1);
      report();

      wait_drained();
      repeat (50) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/krs_pkg.sv
hdl/krs_ctrl.sv
hdl/krs_dp.sv
hdl/keyed_range_stats_top_k.sv
dv/tb_top.sv
